### src/pnfc_pkg.sv
package pnfc_pkg;

    // Operation codes carried by the opcode field.
    localparam logic [2:0] OP_L11_DEC = 3'd0;
    localparam logic [2:0] OP_L11_ENC = 3'd1;
    localparam logic [2:0] OP_L16_DEC = 3'd2;
    localparam logic [2:0] OP_L16_ENC = 3'd3;
    localparam logic [2:0] OP_DIR_DEC = 3'd4;

    // Micro-units per unit, and the reciprocal used for an exact divide by ten
    // of a 16-bit magnitude: (x * DIV10_RECIP) >> DIV10_SHIFT.
    localparam logic [19:0] MICRO_PER_UNIT = 20'd1000000;
    localparam logic [16:0] DIV10_RECIP    = 17'd52429;
    localparam int          DIV10_SHIFT    = 19;

    // LINEAR11 mantissa limits and LINEAR16 saturation value.
    localparam logic [63:0] L11_POS_LIMIT = 64'd1023;
    localparam logic [63:0] L11_NEG_LIMIT = 64'd1024;
    localparam logic [15:0] L16_SAT       = 16'hFFFF;

    // Bit counts fed to the divider.
    localparam logic [6:0] L11_DIV_BITS = 7'd48;
    localparam logic [6:0] DIR_DIV_BITS = 7'd64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SHR,
        ST_SHL,
        ST_CHECK,
        ST_MUL10,
        ST_SUBB,
        ST_DIVST,
        ST_DIVWAIT,
        ST_POST,
        ST_SRCH,
        ST_FINISH
    } state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [6:0]  nbits;
        logic [19:0] divisor;
    } div_req_t;

    // Divider response; quot and big hold until the next start.
    typedef struct packed {
        logic        done;
        logic        big;
        logic [32:0] quot;
    } div_rsp_t;

    // True when a 64-bit two's complement value fits in 32 signed bits.
    function automatic logic fits_s32(input logic [63:0] v);
        return (&v[63:31]) || (~|v[63:31]);
    endfunction

endpackage

### src/pnfc_div.sv
module pnfc_div
    import pnfc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] num_reg, num_next;
    logic [19:0] dsr_reg, dsr_next;
    logic [19:0] rem_reg, rem_next;
    logic [32:0] quot_reg, quot_next;
    logic        big_reg, big_next;

    logic [20:0] trial;
    logic        ge;

    // One quotient bit per cycle: bring down the next dividend bit, trial subtract.
    assign trial = {rem_reg, num_reg[63]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        big_next  = big_reg;
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = req.nbits;
            num_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            quot_next = '0;
            big_next  = 1'b0;
        end else if (busy_reg) begin
            rem_next  = ge ? 20'(trial - {1'b0, dsr_reg}) : trial[19:0];
            quot_next = {quot_reg[31:0], ge};
            // A quotient bit that leaves the register marks the result as too large.
            big_next  = big_reg | quot_reg[32];
            num_next  = {num_reg[62:0], 1'b0};
            cnt_next  = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        num_reg  <= num_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        big_reg  <= big_next;
    end

    assign rsp.done = done_reg;
    assign rsp.big  = big_reg;
    assign rsp.quot = quot_reg;

endmodule

### src/pmbus_numeric_format_converter.sv
// Converts between PMBus LINEAR11, LINEAR16 and DIRECT words and signed 32-bit
// micro-unit values, one item at a time; s_ready is low from the cycle after an
// item is taken until its result has been moved into the output register, which
// holds it until m_ready. Items that need no arithmetic (zero input, zero slope,
// an exponent past the limits, an unknown opcode) go from set-up straight to the
// output register. The time an item takes is set by the shared divider, which
// resolves one quotient bit per cycle, and by the one-bit shifter and times-ten
// step that scale by powers of two and ten.
module pmbus_numeric_format_converter
    import pnfc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic [15:0]        s_word,
    input  logic signed [31:0] s_micro,
    input  logic signed [7:0]  s_exponent,
    input  logic signed [15:0] s_coef_m,
    input  logic signed [15:0] s_coef_b,
    input  logic signed [3:0]  s_coef_r,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_value_micro,
    output logic [15:0]        m_encoded_word,
    output logic               m_valid_res
);

    state_t state_reg, state_next;

    logic [2:0]         op_reg, op_next;
    logic [15:0]        word_reg, word_next;
    logic signed [31:0] micro_reg, micro_next;
    logic signed [7:0]  expo_reg, expo_next;
    logic signed [15:0] m_reg, m_next;
    logic signed [15:0] b_reg, b_next;
    logic signed [3:0]  r_reg, r_next;

    logic [63:0]        acc_reg, acc_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic signed [36:0] bprod_reg, bprod_next;
    logic [63:0]        dnum_reg, dnum_next;
    logic [6:0]         dbits_reg, dbits_next;
    logic [19:0]        ddsr_reg, ddsr_next;

    logic [31:0]        res_val_reg, res_val_next;
    logic [15:0]        res_enc_reg, res_enc_next;
    logic               res_ok_reg, res_ok_next;

    logic               m_valid_reg, m_valid_next;
    logic [31:0]        m_val_reg, m_val_next;
    logic [15:0]        m_enc_reg, m_enc_next;
    logic               m_ok_reg, m_ok_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Scratch values for the set-up and subtract steps.
    logic signed [16:0] mant;
    logic signed [8:0]  e_s;
    logic signed [8:0]  s_l16;
    logic signed [37:0] mprod;
    logic [31:0]        mag32;
    logic [15:0]        yabs;
    logic [32:0]        q10prod;
    logic [15:0]        q10;
    logic signed [4:0]  r_steps;
    logic [63:0]        sub_res;
    logic [8:0]         bits_l16;

    pnfc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign div_req.start    = (state_reg == ST_DIVST);
    assign div_req.dividend = dnum_reg;
    assign div_req.nbits    = dbits_reg;
    assign div_req.divisor  = ddsr_reg;

    // Sequencer: next state and datapath register updates.
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        word_next    = word_reg;
        micro_next   = micro_reg;
        expo_next    = expo_reg;
        m_next       = m_reg;
        b_next       = b_reg;
        r_next       = r_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        bprod_next   = bprod_reg;
        dnum_next    = dnum_reg;
        dbits_next   = dbits_reg;
        ddsr_next    = ddsr_reg;
        res_val_next = res_val_reg;
        res_enc_next = res_enc_reg;
        res_ok_next  = res_ok_reg;
        m_valid_next = m_valid_reg;
        m_val_next   = m_val_reg;
        m_enc_next   = m_enc_reg;
        m_ok_next    = m_ok_reg;
        s_ready      = 1'b0;

        // Mantissa and exponent for the LINEAR decodes.
        if (op_reg == OP_L11_DEC) begin
            mant = 17'(signed'(word_reg[10:0]));
            e_s  = 9'(signed'(word_reg[15:11]));
        end else begin
            mant = signed'({1'b0, word_reg});
            e_s  = 9'(expo_reg);
        end
        mprod    = mant * signed'({1'b0, MICRO_PER_UNIT});
        mag32    = micro_reg[31] ? 32'(-micro_reg) : micro_reg;
        s_l16    = -9'(expo_reg);
        bits_l16 = 9'(s_l16 + 9'sd32);
        yabs     = word_reg[15] ? 16'(-signed'(word_reg)) : word_reg;
        q10prod  = yabs * DIV10_RECIP;
        q10      = 16'(q10prod >> DIV10_SHIFT);
        r_steps  = 5'sd6 - 5'(r_reg);
        sub_res  = acc_reg - 64'(bprod_reg);

        // A taken result frees the output register.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next      = s_opcode;
                    word_next    = s_word;
                    micro_next   = s_micro;
                    expo_next    = s_exponent;
                    m_next       = s_coef_m;
                    b_next       = s_coef_b;
                    r_next       = s_coef_r;
                    res_val_next = '0;
                    res_enc_next = '0;
                    res_ok_next  = 1'b0;
                    state_next   = ST_PREP;
                end
            end

            ST_PREP: begin
                unique case (op_reg)
                    OP_L11_DEC, OP_L16_DEC: begin
                        acc_next = 64'(mprod);
                        if (e_s < 0) begin
                            if (e_s <= -9'sd63) begin
                                // Everything shifted out reads as zero.
                                res_ok_next = 1'b1;
                                state_next  = ST_FINISH;
                            end else begin
                                cnt_next   = 7'(-e_s);
                                state_next = ST_SHR;
                            end
                        end else if (e_s > 0) begin
                            if (e_s >= 9'sd32) begin
                                state_next = ST_FINISH;
                            end else begin
                                cnt_next   = 7'(e_s);
                                state_next = ST_SHL;
                            end
                        end else begin
                            state_next = ST_CHECK;
                        end
                    end
                    OP_L11_ENC: begin
                        res_ok_next = 1'b1;
                        if (micro_reg == 0) begin
                            state_next = ST_FINISH;
                        end else begin
                            neg_next   = micro_reg[31];
                            dnum_next  = {mag32, 32'd0};
                            dbits_next = L11_DIV_BITS;
                            ddsr_next  = MICRO_PER_UNIT;
                            state_next = ST_DIVST;
                        end
                    end
                    OP_L16_ENC: begin
                        res_ok_next = 1'b1;
                        if (micro_reg <= 0 || expo_reg >= 8'sd32 || expo_reg <= -8'sd40) begin
                            state_next = ST_FINISH;
                        end else begin
                            // Long division of micro * 2^-exponent by one million.
                            dnum_next  = {micro_reg, 32'd0};
                            dbits_next = bits_l16[6:0];
                            ddsr_next  = MICRO_PER_UNIT;
                            state_next = ST_DIVST;
                        end
                    end
                    OP_DIR_DEC: begin
                        bprod_next = b_reg * signed'({1'b0, MICRO_PER_UNIT});
                        if (m_reg == 0) begin
                            state_next = ST_FINISH;
                        end else begin
                            if (r_reg == 4'sd7) begin
                                // Y * 10^6 / 10^7 collapses to one divide by ten.
                                acc_next = word_reg[15] ? -64'(q10) : 64'(q10);
                                cnt_next = '0;
                            end else begin
                                acc_next = 64'(signed'(word_reg));
                                cnt_next = 7'(r_steps);
                            end
                            state_next = ST_MUL10;
                        end
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            // Floor scaling by a negative power of two, one bit a cycle.
            ST_SHR: begin
                if (cnt_reg == 7'd0) begin
                    state_next = ST_CHECK;
                end else begin
                    acc_next = 64'(signed'(acc_reg) >>> 1);
                    cnt_next = cnt_reg - 7'd1;
                end
            end

            // Scaling up stops early once the value has left the 32-bit range.
            ST_SHL: begin
                if (cnt_reg == 7'd0 || !fits_s32(acc_reg)) begin
                    state_next = ST_CHECK;
                end else begin
                    acc_next = {acc_reg[62:0], 1'b0};
                    cnt_next = cnt_reg - 7'd1;
                end
            end

            ST_CHECK: begin
                if (fits_s32(acc_reg)) begin
                    res_ok_next  = 1'b1;
                    res_val_next = acc_reg[31:0];
                end
                state_next = ST_FINISH;
            end

            // Multiply by ten as 8x + 2x.
            ST_MUL10: begin
                if (cnt_reg == 7'd0) begin
                    state_next = ST_SUBB;
                end else begin
                    acc_next = {acc_reg[60:0], 3'd0} + {acc_reg[62:0], 1'b0};
                    cnt_next = cnt_reg - 7'd1;
                end
            end

            ST_SUBB: begin
                neg_next   = sub_res[63] ^ m_reg[15];
                dnum_next  = sub_res[63] ? -sub_res : sub_res;
                dbits_next = DIR_DIV_BITS;
                ddsr_next  = m_reg[15] ? 20'(-32'(m_reg)) : 20'(m_reg);
                state_next = ST_DIVST;
            end

            ST_DIVST: begin
                state_next = ST_DIVWAIT;
            end

            ST_DIVWAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_POST;
                end
            end

            ST_POST: begin
                state_next = ST_FINISH;
                unique case (op_reg)
                    OP_L11_ENC: begin
                        acc_next   = 64'(div_rsp.quot);
                        cnt_next   = '0;
                        state_next = ST_SRCH;
                    end
                    OP_L16_ENC: begin
                        if (div_rsp.big || (|div_rsp.quot[32:16])) begin
                            res_enc_next = L16_SAT;
                        end else begin
                            res_enc_next = div_rsp.quot[15:0];
                        end
                    end
                    OP_DIR_DEC: begin
                        if (!div_rsp.big && !div_rsp.quot[32] &&
                            (!div_rsp.quot[31] || (neg_reg && div_rsp.quot[30:0] == '0))) begin
                            res_ok_next  = 1'b1;
                            res_val_next = neg_reg ? -div_rsp.quot[31:0] : div_rsp.quot[31:0];
                        end
                    end
                    default: begin
                        res_ok_next = 1'b0;
                    end
                endcase
            end

            // Lowest LINEAR11 exponent: halve the finest mantissa until it fits.
            ST_SRCH: begin
                if (acc_reg <= (neg_reg ? L11_NEG_LIMIT : L11_POS_LIMIT)) begin
                    res_enc_next = {cnt_reg[4:0] ^ 5'h10,
                                    neg_reg ? -acc_reg[10:0] : acc_reg[10:0]};
                    state_next   = ST_FINISH;
                end else begin
                    acc_next = {1'b0, acc_reg[63:1]};
                    cnt_next = cnt_reg + 7'd1;
                end
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_val_next   = res_val_reg;
                    m_enc_next   = res_enc_reg;
                    m_ok_next    = res_ok_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        word_reg    <= word_next;
        micro_reg   <= micro_next;
        expo_reg    <= expo_next;
        m_reg       <= m_next;
        b_reg       <= b_next;
        r_reg       <= r_next;
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        neg_reg     <= neg_next;
        bprod_reg   <= bprod_next;
        dnum_reg    <= dnum_next;
        dbits_reg   <= dbits_next;
        ddsr_reg    <= ddsr_next;
        res_val_reg <= res_val_next;
        res_enc_reg <= res_enc_next;
        res_ok_reg  <= res_ok_next;
        m_val_reg   <= m_val_next;
        m_enc_reg   <= m_enc_next;
        m_ok_reg    <= m_ok_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_value_micro  = m_val_reg;
    assign m_encoded_word = m_enc_reg;
    assign m_valid_res    = m_ok_reg;

endmodule

### src/pnfc_checker.sv
module pnfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_value_micro,
    input logic [15:0] m_encoded_word,
    input logic        m_valid_res
);

    // A result waiting for the sink stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_micro) && $stable(m_encoded_word))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after an item was taken");

    // A result flagged invalid carries a zero value.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> m_value_micro == 32'd0)
        else $error("nonzero value on an invalid result");

    // An encoded word comes only from an encode, which is always valid and has no value.
    a_encode_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_encoded_word != 16'd0 |-> m_valid_res && m_value_micro == 32'd0)
        else $error("encoded word mixed with a decode result");

endmodule

bind pmbus_numeric_format_converter pnfc_checker u_pnfc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_value_micro  (m_value_micro),
    .m_encoded_word (m_encoded_word),
    .m_valid_res    (m_valid_res)
);

### verif/tb.sv
module tb;
    import pnfc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1330;
    localparam int DRAIN_CYCLES = 120;

    // Signed 32-bit range limits.
    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef struct {
        logic [2:0]         op;
        logic [15:0]        word;
        logic signed [31:0] micro;
        logic signed [7:0]  expo;
        logic signed [15:0] cm;
        logic signed [15:0] cb;
        logic signed [3:0]  cr;
    } conv_item_t;

    typedef struct {
        logic signed [31:0] value;
        logic [15:0]        enc;
        logic               ok;
    } conv_res_t;

    typedef struct {
        conv_item_t item;
        bit         typed;
        conv_res_t  res;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_opcode;
    logic [15:0]        s_word;
    logic signed [31:0] s_micro;
    logic signed [7:0]  s_exponent;
    logic signed [15:0] s_coef_m;
    logic signed [15:0] s_coef_b;
    logic signed [3:0]  s_coef_r;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_value_micro;
    logic [15:0]        m_encoded_word;
    logic               m_valid_res;

    conv_res_t expected_q[$];
    conv_res_t staged_res;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        cycles;
    bit        failed;

    pmbus_numeric_format_converter dut (.*);

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // floor(v / 2^sh), sh below 63.
    function automatic longint floor_div_pow2(longint v, int sh);
        return v >>> sh;
    endfunction

    // mant * 2^e micro-units, with the signed 32-bit range check.
    function automatic bit pow2_scale(longint mant, longint e, output longint r);
        longint v;
        v = mant * 1000000;
        r = 0;
        if (e < 0) begin
            if (-e >= 63) return 1'b1;
            v = floor_div_pow2(v, int'(-e));
        end else if (e > 0) begin
            if (e >= 32) return 1'b0;
            if (v > (S32_MAX >>> e) ||
                v < floor_div_pow2(S32_MIN, int'(e)))
                return 1'b0;
            v = v * (longint'(1) << e);
        end
        if (v > S32_MAX || v < S32_MIN) return 1'b0;
        r = v;
        return 1'b1;
    endfunction

    // LINEAR11 mantissa of a micro-unit value at exponent n, truncating.
    function automatic longint l11_mantissa(longint micro, int n);
        if (n >= 0) return micro / (longint'(1000000) * (longint'(1) << n));
        return (micro * (longint'(1) << (-n))) / 1000000;
    endfunction

    function automatic logic [15:0] l11_pack(longint micro);
        int     n;
        longint y;
        logic [31:0] nb;
        if (micro == 0) return 16'h0000;
        n = 15;
        while (n > -16) begin
            y = l11_mantissa(micro, n - 1);
            if (y > 1023 || y < -1024) break;
            n--;
        end
        y = l11_mantissa(micro, n);
        if (y > 1023) y = 1023;
        if (y < -1024) y = -1024;
        nb = n;
        return {nb[4:0], y[10:0]};
    endfunction

    function automatic logic [15:0] l16_pack(longint micro, longint e);
        longint v;
        longint y;
        v = micro;
        if (micro <= 0) return 16'h0000;
        if (e < 0) begin
            if (-e >= 40) return 16'h0000;
            for (longint k = 0; k < -e; k++) begin
                v = v * 2;
                if (v > (longint'(1) << 40)) v = longint'(1) << 40;
            end
        end else if (e > 0) begin
            if (e >= 63) return 16'h0000;
            v = v >>> e;
        end
        y = v / 1000000;
        return (y > 65535) ? 16'hFFFF : y[15:0];
    endfunction

    // (Y * 10^-R - b) / m in micro-units.
    function automatic bit direct_scale(longint y, longint m, longint b, longint r,
                                        output longint res);
        longint v;
        res = 0;
        if (m == 0) return 1'b0;
        v = y * 1000000;
        for (longint k = 0; k < r; k++) v = v / 10;
        for (longint k = r; k < 0; k++) v = v * 10;
        v = v - b * 1000000;
        v = v / m;
        if (v > S32_MAX || v < S32_MIN) return 1'b0;
        res = v;
        return 1'b1;
    endfunction

    function automatic conv_res_t convert(conv_item_t it);
        conv_res_t r;
        longint    v;
        bit        ok;
        v = 0;
        ok = 1'b0;
        r.enc = 16'h0000;
        case (it.op)
            OP_L11_DEC: ok = pow2_scale(longint'($signed(it.word[10:0])),
                                        longint'($signed(it.word[15:11])), v);
            OP_L11_ENC: begin
                r.enc = l11_pack(longint'(it.micro));
                ok = 1'b1;
            end
            OP_L16_DEC: ok = pow2_scale(longint'({1'b0, it.word}), longint'(it.expo), v);
            OP_L16_ENC: begin
                r.enc = l16_pack(longint'(it.micro), longint'(it.expo));
                ok = 1'b1;
            end
            OP_DIR_DEC: ok = direct_scale(longint'($signed(it.word)), longint'(it.cm),
                                          longint'(it.cb), longint'(it.cr), v);
            default: ok = 1'b0;
        endcase
        if (!ok) v = 0;
        r.value = v[31:0];
        r.ok = ok;
        return r;
    endfunction

    function automatic conv_item_t random_item();
        conv_item_t it;
        int         sel;
        sel = $urandom_range(99);
        if (sel < 18) it.op = OP_L11_DEC;
        else if (sel < 38) it.op = OP_L11_ENC;
        else if (sel < 56) it.op = OP_L16_DEC;
        else if (sel < 76) it.op = OP_L16_ENC;
        else if (sel < 96) it.op = OP_DIR_DEC;
        else it.op = 3'($urandom_range(7, 5));
        it.word = 16'($urandom);
        case ($urandom_range(3))
            0: it.micro = $urandom;
            1: it.micro = $signed(32'($urandom_range(2000000))) - 1000000;
            2: it.micro = $signed(32'($urandom)) >>> $urandom_range(31);
            default: it.micro = $signed(32'($urandom_range(100000000)));
        endcase
        it.expo = ($urandom_range(1)) ? 8'($urandom) : 8'($signed($urandom_range(50)) - 25);
        it.cm = 16'($urandom);
        if ($urandom_range(9) == 0) it.cm = 16'sd0;
        it.cb = 16'($urandom);
        it.cr = 4'($urandom);
        return it;
    endfunction

    // Drive one item; called right after the previous item was accepted.
    task automatic send_item(conv_item_t it, bit typed, conv_res_t res);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_opcode   <= it.op;
        s_word     <= it.word;
        s_micro    <= it.micro;
        s_exponent <= it.expo;
        s_coef_m   <= it.cm;
        s_coef_b   <= it.cb;
        s_coef_r   <= it.cr;
        staged_res <= typed ? res : convert(it);
        s_valid    <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    // Receiver stalls.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Record the expectation of each accepted item.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) expected_q.push_back(staged_res);
    end

    // Compare each result item with the oldest expectation.
    always @(posedge aclk) begin
        conv_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result value=%0d word=%h valid=%b",
                         $time, m_value_micro, m_encoded_word, m_valid_res);
                failed = 1'b1;
            end else begin
                e = expected_q.pop_front();
                if (m_value_micro !== e.value) begin
                    $display("%0t: value_micro expected %0d actual %0d",
                             $time, e.value, m_value_micro);
                    failed = 1'b1;
                end
                if (m_encoded_word !== e.enc) begin
                    $display("%0t: encoded_word expected %h actual %h",
                             $time, e.enc, m_encoded_word);
                    failed = 1'b1;
                end
                if (m_valid_res !== e.ok) begin
                    $display("%0t: valid_res expected %b actual %b",
                             $time, e.ok, m_valid_res);
                    failed = 1'b1;
                end
            end
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[pmbus_numeric_format_converter] ERROR");
            $finish;
        end
    end

    initial begin
        stim_row_t  rows[$];
        stim_row_t  row;
        conv_item_t it;
        conv_res_t  zero_res;
        int         idle_tab[4][2];

        failed = 1'b0;
        cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_opcode = OP_L11_DEC;
        s_word = '0;
        s_micro = '0;
        s_exponent = '0;
        s_coef_m = '0;
        s_coef_b = '0;
        s_coef_r = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        staged_res = '{default: '0};
        zero_res = '{default: '0};
        idle_tab = '{'{0, 0}, '{60, 0}, '{0, 60}, '{11, 11}};

        // Directed items: op, word, micro, exponent, m, b, R, typed, expected.
        rows = '{
            '{'{OP_L11_DEC, 16'h0000, 0, 0, 1, 0, 0}, 1, '{0, 16'h0, 1'b1}},
            '{'{OP_L11_DEC, 16'h03FF, 0, 0, 1, 0, 0}, 0, zero_res},
            '{'{OP_L11_DEC, 16'h0400, 0, 0, 1, 0, 0}, 0, zero_res},
            '{'{OP_L11_DEC, 16'h7BFF, 0, 0, 1, 0, 0}, 0, zero_res},
            '{'{OP_L11_DEC, 16'h8401, 0, 0, 1, 0, 0}, 0, zero_res},
            '{'{OP_L11_DEC, 16'hFFFF, 0, 0, 1, 0, 0}, 0, zero_res},
            '{'{OP_L11_ENC, 16'h0000, 0, 0, 1, 0, 0}, 1, '{0, 16'h0, 1'b1}},
            '{'{OP_L11_ENC, 16'h0000, 32'h7FFFFFFF, 0, 1, 0, 0}, 0, zero_res},
            '{'{OP_L11_ENC, 16'h0000, 32'h80000000, 0, 1, 0, 0}, 0, zero_res},
            '{'{OP_L11_ENC, 16'h0000, -1, 0, 1, 0, 0}, 0, zero_res},
            '{'{OP_L16_DEC, 16'hFFFF, 0, -128, 1, 0, 0}, 1, '{0, 16'h0, 1'b1}},
            '{'{OP_L16_DEC, 16'h0000, 0, 32, 1, 0, 0}, 1, '{0, 16'h0, 1'b0}},
            '{'{OP_L16_DEC, 16'hFFFF, 0, 127, 1, 0, 0}, 1, '{0, 16'h0, 1'b0}},
            '{'{OP_L16_DEC, 16'hFFFF, 0, -15, 1, 0, 0}, 0, zero_res},
            '{'{OP_L16_ENC, 16'h0000, -1, 0, 1, 0, 0}, 1, '{0, 16'h0, 1'b1}},
            '{'{OP_L16_ENC, 16'h0000, 5000000, -40, 1, 0, 0}, 1, '{0, 16'h0, 1'b1}},
            '{'{OP_L16_ENC, 16'h0000, 32'h7FFFFFFF, 63, 1, 0, 0}, 1,
              '{0, 16'h0, 1'b1}},
            '{'{OP_L16_ENC, 16'h0000, 32'h7FFFFFFF, -39, 1, 0, 0}, 1,
              '{0, 16'hFFFF, 1'b1}},
            '{'{OP_L16_ENC, 16'h0000, 12345678, -9, 1, 0, 0}, 0, zero_res},
            '{'{OP_DIR_DEC, 16'h1234, 0, 0, 0, 5, 0}, 1, '{0, 16'h0, 1'b0}},
            '{'{OP_DIR_DEC, 16'h7FFF, 0, 0, 1, 16'sh8000, -8}, 0, zero_res},
            '{'{OP_DIR_DEC, 16'h8000, 0, 0, 16'sh8000, 16'sh7FFF, 7}, 0, zero_res},
            '{'{OP_DIR_DEC, 16'h8000, 0, 0, -1, 0, -3}, 0, zero_res},
            '{'{3'd5, 16'hFFFF, -1, -1, -1, -1, -1}, 1, '{0, 16'h0, 1'b0}},
            '{'{3'd7, 16'hFFFF, -1, -1, -1, -1, -1}, 1, '{0, 16'h0, 1'b0}}
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);

        // Hold off until every result has come back.
        wait_drained();

        // Random part in four idling phases.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_tab[ph][0];
            recv_stall_pct = idle_tab[ph][1];
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                it = random_item();
                send_item(it, 1'b0, zero_res);
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (!failed) begin
            $display("[pmbus_numeric_format_converter] OK");
        end else begin
            $display("[pmbus_numeric_format_converter] ERROR");
        end
        $finish;
    end

endmodule
